// ----- hw/rtl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and constants shared by the bounded double-ended queue modules.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // Action codes carried by an input item (codes above ACT_DUMP are ignored)
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_DUMP       = 3'd4
  } action_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Back-end sequencer states
  typedef enum logic {
    BS_IDLE,
    BS_DUMP
  } bstate_e;

  // Input item as seen on the ports
  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
  } in_item_t;

  // Classified command handed from front end to back end
  typedef struct packed {
    action_e            op;
    logic signed [31:0] value;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               last;
  } out_item_t;

  // Queue depths between the parts
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 4;

endpackage

// ----- hw/rtl/bdq_ram.sv -----
// ----------------------------------------------------------------------------
// bdq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bdq_fifo.sv -----
// ----------------------------------------------------------------------------
// bdq_fifo
// Small register FIFO used for the command queue and the result queue.
// ----------------------------------------------------------------------------
module bdq_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill-count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hw/rtl/bdq_front.sv -----
// ----------------------------------------------------------------------------
// bdq_front
// Front end: accepts input items, drops undefined actions, and queues the
// classified commands for the back end.
// ----------------------------------------------------------------------------
module bdq_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_push_i,
  input  bdq_pkg::in_item_t in_item_i,
  output logic              in_full_o,
  output logic              cmd_empty_o,
  output bdq_pkg::cmd_t     cmd_o,
  input  logic              cmd_pop_i
);

  localparam int unsigned CW = $clog2(bdq_pkg::CMD_DEPTH + 1);

  logic                           act_valid;
  bdq_pkg::cmd_t                  cmd_in;
  logic [$bits(bdq_pkg::cmd_t)-1:0] cmd_raw;
  logic [CW-1:0]                  cmd_cnt;

  // classify: only defined action codes enter the command queue
  assign act_valid    = (in_item_i.action <= bdq_pkg::ACT_DUMP);
  assign cmd_in.op    = bdq_pkg::action_e'(in_item_i.action);
  assign cmd_in.value = in_item_i.value;

  bdq_fifo #(
    .WIDTH ($bits(bdq_pkg::cmd_t)),
    .DEPTH (bdq_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_push_i && act_valid),
    .wdata_i (cmd_in),
    .full_o  (in_full_o),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_raw),
    .empty_o (cmd_empty_o),
    .count_o (cmd_cnt)
  );

  assign cmd_o = bdq_pkg::cmd_t'(cmd_raw);

  // cmd_cnt is informational only; tie it into nothing else
  logic cmd_cnt_unused;
  assign cmd_cnt_unused = ^cmd_cnt;

endmodule

// ----- hw/rtl/bdq_back.sv -----
// ----------------------------------------------------------------------------
// bdq_back
// Back end: owns the ring store, front index and element count, carries out
// one command at a time and writes results into the result queue.
// ----------------------------------------------------------------------------
module bdq_back #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_empty_i,
  input  bdq_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               res_empty_o,
  output bdq_pkg::out_item_t res_item_o,
  input  logic               res_pop_i
);

  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned SW  = CW + 1;
  localparam int unsigned RCW = $clog2(bdq_pkg::RES_DEPTH + 1);

  bdq_pkg::bstate_e state_q, state_d;
  logic [AW-1:0]    front_q, front_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             rd_pend_q, rd_pend_d;
  logic             rd_last_q, rd_last_d;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [31:0]      ram_rdata;

  logic             is_full, is_empty, room, take, dump_last;
  logic             cmd_reads, dump_start;
  logic             dir_wr;
  bdq_pkg::status_e dir_status;

  logic                                  res_wr, res_full;
  bdq_pkg::out_item_t                    res_wdata;
  logic [$bits(bdq_pkg::out_item_t)-1:0] res_raw;
  logic [RCW-1:0]                        res_cnt;

  // ring slot of an offset from the front, modulo DEPTH
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign is_full   = (count_q == CW'(DEPTH));
  assign is_empty  = (count_q == '0);
  assign dump_last = ((idx_q + CW'(1)) == count_q);

  // a read in flight still needs a slot in the result queue
  assign room = ((RCW + 1)'(res_cnt) + (RCW + 1)'(rd_pend_q)) < (RCW + 1)'(bdq_pkg::RES_DEPTH);

  assign cmd_reads  = ((cmd_i.op == bdq_pkg::ACT_POP_FRONT) ||
                       (cmd_i.op == bdq_pkg::ACT_POP_BACK)) && !is_empty;
  assign dump_start = (cmd_i.op == bdq_pkg::ACT_DUMP) && !is_empty;

  // direct results may not collide with returning read data
  assign take = (state_q == bdq_pkg::BS_IDLE) && !cmd_empty_i && room &&
                (cmd_reads || dump_start || !rd_pend_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bdq_pkg::BS_IDLE: begin
        if (take && dump_start) begin
          state_d = bdq_pkg::BS_DUMP;
        end
      end
      bdq_pkg::BS_DUMP: begin
        if (room && dump_last) begin
          state_d = bdq_pkg::BS_IDLE;
        end
      end
      default: state_d = bdq_pkg::BS_IDLE;
    endcase
  end

  // datapath and control outputs
  always_comb begin
    cmd_pop_o  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = front_q;
    ram_re     = 1'b0;
    ram_raddr  = front_q;
    front_d    = front_q;
    count_d    = count_q;
    idx_d      = idx_q;
    rd_pend_d  = 1'b0;
    rd_last_d  = rd_last_q;
    dir_wr     = 1'b0;
    dir_status = bdq_pkg::STAT_OK;
    unique case (state_q)
      bdq_pkg::BS_IDLE: begin
        if (take) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            bdq_pkg::ACT_PUSH_FRONT: begin
              dir_wr = 1'b1;
              if (is_full) begin
                dir_status = bdq_pkg::STAT_FULL;
              end else begin
                front_d   = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
                ram_we    = 1'b1;
                ram_waddr = front_d;
                count_d   = count_q + CW'(1);
              end
            end
            bdq_pkg::ACT_PUSH_BACK: begin
              dir_wr = 1'b1;
              if (is_full) begin
                dir_status = bdq_pkg::STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = wrap_add(front_q, count_q);
                count_d   = count_q + CW'(1);
              end
            end
            bdq_pkg::ACT_POP_FRONT: begin
              if (is_empty) begin
                dir_wr     = 1'b1;
                dir_status = bdq_pkg::STAT_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = front_q;
                rd_pend_d = 1'b1;
                rd_last_d = 1'b1;
                front_d   = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
                count_d   = count_q - CW'(1);
              end
            end
            bdq_pkg::ACT_POP_BACK: begin
              if (is_empty) begin
                dir_wr     = 1'b1;
                dir_status = bdq_pkg::STAT_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = wrap_add(front_q, count_q - CW'(1));
                rd_pend_d = 1'b1;
                rd_last_d = 1'b1;
                count_d   = count_q - CW'(1);
              end
            end
            bdq_pkg::ACT_DUMP: begin
              if (is_empty) begin
                dir_wr     = 1'b1;
                dir_status = bdq_pkg::STAT_EMPTY;
              end else begin
                idx_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      bdq_pkg::BS_DUMP: begin
        // one element read per cycle while the result queue has room, front to back
        if (room) begin
          ram_re    = 1'b1;
          ram_raddr = wrap_add(front_q, idx_q);
          rd_pend_d = 1'b1;
          rd_last_d = dump_last;
          idx_d     = idx_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bdq_pkg::BS_IDLE;
      front_q   <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  // payload flag riding with the read
  always_ff @(posedge clk_i) begin
    rd_last_q <= rd_last_d;
  end

  bdq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_i.value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result assembly: returning read data or a direct status result
  assign res_wr = rd_pend_q || dir_wr;
  always_comb begin
    if (rd_pend_q) begin
      res_wdata.status  = bdq_pkg::STAT_OK;
      res_wdata.element = ram_rdata;
      res_wdata.last    = rd_last_q;
    end else begin
      res_wdata.status  = dir_status;
      res_wdata.element = '0;
      res_wdata.last    = 1'b1;
    end
  end

  bdq_fifo #(
    .WIDTH ($bits(bdq_pkg::out_item_t)),
    .DEPTH (bdq_pkg::RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_wr),
    .wdata_i (res_wdata),
    .full_o  (res_full),
    .pop_i   (res_pop_i),
    .rdata_o (res_raw),
    .empty_o (res_empty_o),
    .count_o (res_cnt)
  );

  assign res_item_o = bdq_pkg::out_item_t'(res_raw);

  // the room check keeps the queue from overflowing; full is not needed
  logic res_full_unused;
  assign res_full_unused = res_full;

endmodule

// ----- hw/rtl/bounded_double_ended_queue_core.sv -----
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_core
// Bounded double-ended queue of signed 32-bit values with push/pop at both
// ends and a front-to-back dump.
// ----------------------------------------------------------------------------
// A two-entry command queue takes items from the push side; a back-end
// sequencer carries them out one at a time against a DEPTH-entry ring RAM and
// writes results into a four-entry result queue read through empty/pop. A
// push, or any command that ends in an empty/full status, gets its result
// written directly when the back end takes it; a pop issues a RAM read whose
// value comes back through the registered read port, and pops issue back to
// back. A direct result that follows a pop waits for the read data to land.
// A dump of N elements first moves the sequencer into its dump state, then
// reads one element per cycle while the result queue has room, and gives N
// results, the last one marked. Undefined action codes are accepted and give
// no result. No clearing pass is needed after reset.
module bounded_double_ended_queue_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  bdq_pkg::in_item_t  in_item_i,
  output logic               full,
  output logic               empty,
  output bdq_pkg::out_item_t out_item_o,
  input  logic               pop
);

  logic          cmd_empty;
  logic          cmd_pop;
  bdq_pkg::cmd_t cmd;

  // front end: accept and classify
  bdq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_push_i   (push),
    .in_item_i   (in_item_i),
    .in_full_o   (full),
    .cmd_empty_o (cmd_empty),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // back end: execute against the ring store
  bdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_empty_o (empty),
    .res_item_o  (out_item_o),
    .res_pop_i   (pop)
  );

  // error results always end their item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_item_o.status != bdq_pkg::STAT_OK)) |-> out_item_o.last)
    else $error("error result without last");

  // error results carry no element
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_item_o.status != bdq_pkg::STAT_OK)) |-> (out_item_o.element == '0))
    else $error("error result with nonzero element");

  // only defined status codes are produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.status != 2'd3))
    else $error("undefined status code");

  // a command leaves the queue only when one is waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("command taken from empty queue");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded double-ended queue core. A short table
// of directed transfers hits empty and one-element corners, value extremes and
// the undefined action codes. A random stream then swings the fill level
// between empty and full under several idle/stall mixes, including one long
// hold-off on the result side. Every result is checked against the table's
// expected result or an in-bench deque predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned RANDOM_ITEMS = 406;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 20;

  // Action codes the core accepts but ignores
  localparam logic [2:0] ACT_UNDEF_LO  = 3'd5;
  localparam logic [2:0] ACT_UNDEF_MID = 3'd6;
  localparam logic [2:0] ACT_UNDEF_HI  = 3'd7;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam bdq_pkg::out_item_t NO_RESULT = '0;

  typedef enum {
    PH_DIRECTED,
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } phase_e;

  // One directed transfer; want is used only when typed is set
  typedef struct {
    logic [2:0]         action;
    logic signed [31:0] value;
    bit                 typed;
    bdq_pkg::out_item_t want;
  } dir_row_t;

  localparam int unsigned N_DIRECTED = 24;

  dir_row_t directed_ops [N_DIRECTED] = '{
    '{bdq_pkg::ACT_POP_FRONT,  32'sd0,  1'b1, '{bdq_pkg::STAT_EMPTY, 32'sd0, 1'b1}},
    '{bdq_pkg::ACT_POP_BACK,   32'sd0,  1'b1, '{bdq_pkg::STAT_EMPTY, 32'sd0, 1'b1}},
    '{bdq_pkg::ACT_DUMP,       32'sd0,  1'b1, '{bdq_pkg::STAT_EMPTY, 32'sd0, 1'b1}},
    '{bdq_pkg::ACT_PUSH_BACK,  VAL_MAX, 1'b1, '{bdq_pkg::STAT_OK,    32'sd0, 1'b1}},
    // pop at the back of a one-element queue
    '{bdq_pkg::ACT_POP_BACK,   32'sd0,  1'b1, '{bdq_pkg::STAT_OK,    VAL_MAX, 1'b1}},
    // push at the back of an empty queue must store exactly once
    '{bdq_pkg::ACT_PUSH_BACK,  VAL_MIN, 1'b1, '{bdq_pkg::STAT_OK,    32'sd0, 1'b1}},
    '{bdq_pkg::ACT_DUMP,       32'sd0,  1'b1, '{bdq_pkg::STAT_OK,    VAL_MIN, 1'b1}},
    '{bdq_pkg::ACT_PUSH_FRONT, -32'sd1, 1'b1, '{bdq_pkg::STAT_OK,    32'sd0, 1'b1}},
    '{bdq_pkg::ACT_PUSH_BACK,  32'sd0,  1'b1, '{bdq_pkg::STAT_OK,    32'sd0, 1'b1}},
    '{bdq_pkg::ACT_PUSH_FRONT, 32'sh5555_5555, 1'b1, '{bdq_pkg::STAT_OK, 32'sd0, 1'b1}},
    '{bdq_pkg::ACT_PUSH_BACK,  32'shAAAA_AAAA, 1'b1, '{bdq_pkg::STAT_OK, 32'sd0, 1'b1}},
    '{bdq_pkg::ACT_DUMP,       32'sd0,  1'b0, NO_RESULT},
    '{ACT_UNDEF_LO,            32'sd12345, 1'b0, NO_RESULT},
    '{ACT_UNDEF_MID,           VAL_MAX, 1'b0, NO_RESULT},
    '{ACT_UNDEF_HI,            -32'sd1, 1'b0, NO_RESULT},
    '{bdq_pkg::ACT_POP_FRONT,  32'sd0,  1'b0, NO_RESULT},
    '{bdq_pkg::ACT_POP_BACK,   32'sd0,  1'b0, NO_RESULT},
    '{bdq_pkg::ACT_POP_FRONT,  32'sd0,  1'b0, NO_RESULT},
    '{bdq_pkg::ACT_POP_BACK,   32'sd0,  1'b0, NO_RESULT},
    '{bdq_pkg::ACT_POP_FRONT,  32'sd0,  1'b0, NO_RESULT},
    '{bdq_pkg::ACT_POP_FRONT,  32'sd0,  1'b1, '{bdq_pkg::STAT_EMPTY, 32'sd0, 1'b1}},
    '{bdq_pkg::ACT_DUMP,       32'sd0,  1'b1, '{bdq_pkg::STAT_EMPTY, 32'sd0, 1'b1}},
    '{bdq_pkg::ACT_PUSH_FRONT, VAL_MIN, 1'b1, '{bdq_pkg::STAT_OK,    32'sd0, 1'b1}},
    '{bdq_pkg::ACT_POP_FRONT,  32'sd0,  1'b1, '{bdq_pkg::STAT_OK,    VAL_MIN, 1'b1}}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               pop;
  logic               full;
  logic               empty;
  bdq_pkg::in_item_t  in_item;
  bdq_pkg::out_item_t out_item;

  phase_e    phase = PH_DIRECTED;
  bit        pressure_done = 1'b0;
  int        errors = 0;

  // Deque predictor state
  logic signed [31:0] deque_ring [DEPTH];
  int unsigned        head_idx = 0;
  int unsigned        fill_cnt = 0;
  bdq_pkg::out_item_t step_results [$];
  bdq_pkg::out_item_t due_results [$];

  bounded_double_ended_queue_core #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .in_item_i (in_item),
    .full      (full),
    .empty     (empty),
    .out_item_o(out_item),
    .pop       (pop)
  );

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
  end

  // Hard stop
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int unsigned send_gap_pct();
    case (phase)
      PH_SEND_IDLE: return 82;
      PH_BOTH:      return 8;
      default:      return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall_pct();
    case (phase)
      PH_RECV_STALL: return 82;
      PH_BOTH:       return 8;
      default:       return 0;
    endcase
  endfunction

  // Apply one action to the predicted deque; results land in step_results
  function automatic void apply_deque_action(bdq_pkg::in_item_t it);
    bdq_pkg::out_item_t r;
    step_results.delete();
    r = '{status: bdq_pkg::STAT_OK, element: 32'sd0, last: 1'b1};
    case (it.action)
      bdq_pkg::ACT_PUSH_FRONT, bdq_pkg::ACT_PUSH_BACK: begin
        if (fill_cnt == DEPTH) begin
          r.status = bdq_pkg::STAT_FULL;
        end else if (it.action == bdq_pkg::ACT_PUSH_FRONT) begin
          head_idx = (head_idx + DEPTH - 1) % DEPTH;
          deque_ring[head_idx] = it.value;
          fill_cnt++;
        end else begin
          deque_ring[(head_idx + fill_cnt) % DEPTH] = it.value;
          fill_cnt++;
        end
        step_results.push_back(r);
      end
      bdq_pkg::ACT_POP_FRONT, bdq_pkg::ACT_POP_BACK: begin
        if (fill_cnt == 0) begin
          r.status = bdq_pkg::STAT_EMPTY;
        end else if (it.action == bdq_pkg::ACT_POP_FRONT) begin
          r.element = deque_ring[head_idx];
          head_idx  = (head_idx + 1) % DEPTH;
          fill_cnt--;
        end else begin
          r.element = deque_ring[(head_idx + fill_cnt - 1) % DEPTH];
          fill_cnt--;
        end
        step_results.push_back(r);
      end
      bdq_pkg::ACT_DUMP: begin
        if (fill_cnt == 0) begin
          r.status = bdq_pkg::STAT_EMPTY;
          step_results.push_back(r);
        end else begin
          for (int unsigned i = 0; i < fill_cnt; i++) begin
            r.element = deque_ring[(head_idx + i) % DEPTH];
            r.last    = (i + 1 == fill_cnt);
            step_results.push_back(r);
          end
        end
      end
      default: ;  // undefined codes are dropped silently
    endcase
  endfunction

  // Offer one item, wait for the transfer, then book its expected results.
  // Called and returns at a falling edge.
  task automatic send_item(bdq_pkg::in_item_t it, bit typed, bdq_pkg::out_item_t want);
    while ($urandom_range(0, 99) < send_gap_pct()) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full !== 1'b0);
    apply_deque_action(it);
    if (typed) begin
      due_results.push_back(want);
    end else begin
      foreach (step_results[i]) due_results.push_back(step_results[i]);
    end
    @(negedge clk_i);
  endtask

  // Stimulus: directed table, random phases, drain, verdict
  initial begin
    bdq_pkg::in_item_t it;
    int unsigned       defined_sent;
    int unsigned       pick;
    bit                growing;

    push    = 1'b0;
    in_item = '0;
    defined_sent = 0;
    growing = 1'b1;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);

    foreach (directed_ops[i]) begin
      it.action = directed_ops[i].action;
      it.value  = directed_ops[i].value;
      send_item(it, directed_ops[i].typed, directed_ops[i].want);
    end

    // Random stream: fill level swings between empty and full
    while (defined_sent < RANDOM_ITEMS) begin
      case (defined_sent * 4 / RANDOM_ITEMS)
        0:       phase = PH_FREE;
        1:       phase = PH_SEND_IDLE;
        2:       phase = PH_RECV_STALL;
        default: phase = PH_BOTH;
      endcase
      if (growing && fill_cnt == DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
      if (!growing && fill_cnt == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;

      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        it.action = 3'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
      end else if (pick < 10) begin
        it.action = bdq_pkg::ACT_DUMP;
      end else if ((pick < 85) == growing) begin
        it.action = $urandom_range(0, 1) ? bdq_pkg::ACT_PUSH_FRONT : bdq_pkg::ACT_PUSH_BACK;
      end else begin
        it.action = $urandom_range(0, 1) ? bdq_pkg::ACT_POP_FRONT : bdq_pkg::ACT_POP_BACK;
      end

      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       it.value = VAL_MIN;
          1:       it.value = VAL_MAX;
          2:       it.value = 32'sd0;
          default: it.value = -32'sd1;
        endcase
      end else begin
        it.value = $urandom;
      end

      send_item(it, 1'b0, NO_RESULT);
      if (it.action <= bdq_pkg::ACT_DUMP) defined_sent++;
    end

    push <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off to back up the core
  initial begin
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (phase == PH_FREE && !pressure_done) begin
        pressure_done = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      pop <= !($urandom_range(0, 99) < recv_stall_pct());
    end
  end

  task automatic compare_field(string fname, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  // Check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    bdq_pkg::out_item_t want;
    if (rst_ni && pop && empty === 1'b0) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: status %0d element %0d last %0b",
                 $time, out_item.status, out_item.element, out_item.last);
      end else begin
        want = due_results.pop_front();
        compare_field("status", 32'(want.status), 32'(out_item.status));
        compare_field("element", want.element, out_item.element);
        compare_field("last", 32'(want.last), 32'(out_item.last));
      end
    end
  end

endmodule
